// ===== rtl/core/crd_pkg.sv =====
// ----------------------------------------------------------------------------
// crd_pkg
// Shared types and constants of the character reference decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crd_pkg;

    localparam int CP_W           = 21;
    localparam int BYTE_W         = 8;
    localparam int SPAN_W         = 8;
    localparam int NAME_CHARS_DEF = 4;

    localparam logic [CP_W-1:0] CP_LIMIT_RST = 21'd1114111;

    // Name prefixes packed first byte lowest
    localparam logic [31:0] NAME_AMP  = 32'h0070_6d61;
    localparam logic [31:0] NAME_APOS = 32'h736f_7061;
    localparam logic [31:0] NAME_GT   = 32'h0000_7467;
    localparam logic [31:0] NAME_LT   = 32'h0000_746c;
    localparam logic [31:0] NAME_QUOT = 32'h746f_7571;

    localparam int LEN_AMP  = 3;
    localparam int LEN_APOS = 4;
    localparam int LEN_GT   = 2;
    localparam int LEN_LT   = 2;
    localparam int LEN_QUOT = 4;

    localparam logic [6:0] CP_AMP  = 7'd38;
    localparam logic [6:0] CP_APOS = 7'd39;
    localparam logic [6:0] CP_GT   = 7'd62;
    localparam logic [6:0] CP_LT   = 7'd60;
    localparam logic [6:0] CP_QUOT = 7'd34;

    localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3b;
    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_X_LO  = 8'h78;
    localparam logic [BYTE_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_A_LO  = 8'h61;
    localparam logic [BYTE_W-1:0] CH_F_LO  = 8'h66;
    localparam logic [BYTE_W-1:0] CH_A_UP  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_F_UP  = 8'h46;
    localparam logic [BYTE_W-1:0] CH_Z_UP  = 8'h5a;

    localparam logic ERR_OK      = 1'b0;
    localparam logic ERR_UNKNOWN = 1'b1;

    typedef struct packed {
        logic [CP_W-1:0]   cp_value;
        logic              error_code;
        logic [SPAN_W-1:0] ref_span;
    } t_result;

endpackage

// ===== rtl/core/crd_scan.sv =====
// ----------------------------------------------------------------------------
// crd_scan
// Reference state and per-byte decode: phase, code point accumulator,
// kept name prefix and span count; forms the result on the closing byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crd_scan #(
    parameter int NAME_CHARS = crd_pkg::NAME_CHARS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic [crd_pkg::BYTE_W-1:0]  i_byte,
    input  logic [crd_pkg::CP_W-1:0]    i_limit,
    output logic                        o_emit,
    output crd_pkg::t_result            o_result
);
    import crd_pkg::*;

    localparam int NW  = 8 * NAME_CHARS;
    localparam int NCW = $clog2(NAME_CHARS + 1);
    localparam int AW  = CP_W + 5;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_AMP   = 3'd1;
    localparam logic [2:0] PH_HASH  = 3'd2;
    localparam logic [2:0] PH_DEC   = 3'd3;
    localparam logic [2:0] PH_HEX   = 3'd4;
    localparam logic [2:0] PH_NAMED = 3'd5;

    logic [2:0]        r_phase,    n_phase;
    logic [CP_W-1:0]   r_acc,      n_acc;
    logic              r_sat,      n_sat;
    logic [NW-1:0]     r_name,     n_name;
    logic [NCW-1:0]    r_name_cnt, n_name_cnt;
    logic [SPAN_W-1:0] r_span,     n_span;

    logic              is_dec, is_hex_lo, is_hex_up;
    logic [3:0]        dec_digit, hex_digit;
    logic [AW-1:0]     dec_next, hex_next;
    logic              dec_sat, hex_sat;
    logic [BYTE_W-1:0] low_byte;
    logic [6:0]        named_cp;
    logic              named_hit;

    assign is_dec    = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign is_hex_lo = (i_byte >= CH_A_LO) && (i_byte <= CH_F_LO);
    assign is_hex_up = (i_byte >= CH_A_UP) && (i_byte <= CH_F_UP);
    assign dec_digit = 4'(i_byte - CH_0);

    always_comb begin
        if (is_hex_lo) begin
            hex_digit = 4'(i_byte - CH_A_LO + 8'd10);
        end else if (is_hex_up) begin
            hex_digit = 4'(i_byte - CH_A_UP + 8'd10);
        end else begin
            hex_digit = dec_digit;
        end
    end

    assign dec_next = ({5'b0, r_acc} << 3) + ({5'b0, r_acc} << 1) + AW'(dec_digit);
    assign hex_next = ({5'b0, r_acc} << 4) + AW'(hex_digit);
    assign dec_sat  = r_sat || (dec_next > AW'(i_limit));
    assign hex_sat  = r_sat || (hex_next > AW'(i_limit));

    assign low_byte = ((i_byte >= CH_A_UP) && (i_byte <= CH_Z_UP)) ? i_byte + 8'd32
                                                                    : i_byte;

    always_comb begin
        named_hit = 1'b1;
        named_cp  = '0;
        if (r_name_cnt == NCW'(LEN_AMP) && r_name == NW'(NAME_AMP)) begin
            named_cp = CP_AMP;
        end else if (r_name_cnt == NCW'(LEN_APOS) && r_name == NW'(NAME_APOS)) begin
            named_cp = CP_APOS;
        end else if (r_name_cnt == NCW'(LEN_GT) && r_name == NW'(NAME_GT)) begin
            named_cp = CP_GT;
        end else if (r_name_cnt == NCW'(LEN_LT) && r_name == NW'(NAME_LT)) begin
            named_cp = CP_LT;
        end else if (r_name_cnt == NCW'(LEN_QUOT) && r_name == NW'(NAME_QUOT)) begin
            named_cp = CP_QUOT;
        end else begin
            named_hit = 1'b0;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_sat      = r_sat;
        n_name     = r_name;
        n_name_cnt = r_name_cnt;
        n_span     = r_span;
        o_emit     = 1'b0;
        o_result   = '0;

        if (i_byte == CH_AMP) begin
            n_phase    = PH_AMP;
            n_acc      = '0;
            n_sat      = 1'b0;
            n_name     = '0;
            n_name_cnt = '0;
            n_span     = SPAN_W'(1);
        end else if (r_phase != PH_IDLE) begin
            n_span = (r_span != '1) ? r_span + 1'b1 : r_span;
            if (i_byte == CH_SEMI) begin
                o_emit              = 1'b1;
                o_result.ref_span   = n_span;
                if (r_phase == PH_AMP || r_phase == PH_NAMED) begin
                    if (!named_hit) begin
                        o_result.error_code = ERR_UNKNOWN;
                    end else if (CP_W'(named_cp) > i_limit) begin
                        o_result.cp_value = i_limit;
                    end else begin
                        o_result.cp_value = CP_W'(named_cp);
                    end
                end else begin
                    o_result.cp_value = r_acc;
                end
                n_phase    = PH_IDLE;
                n_span     = '0;
                n_acc      = '0;
                n_sat      = 1'b0;
                n_name     = '0;
                n_name_cnt = '0;
            end else begin
                case (r_phase)
                    PH_AMP, PH_NAMED: begin
                        if (r_phase == PH_AMP && i_byte == CH_HASH) begin
                            n_phase = PH_HASH;
                        end else begin
                            n_phase = PH_NAMED;
                            if (r_name_cnt < NCW'(NAME_CHARS)) begin
                                for (int k = 0; k < NAME_CHARS; k++) begin
                                    if (r_name_cnt == NCW'(k)) begin
                                        n_name[k*8 +: 8] = low_byte;
                                    end
                                end
                                n_name_cnt = r_name_cnt + 1'b1;
                            end
                        end
                    end
                    PH_HASH, PH_DEC: begin
                        if (r_phase == PH_HASH && (i_byte == CH_X_LO || i_byte == CH_X_UP)) begin
                            n_phase = PH_HEX;
                        end else begin
                            n_phase = PH_DEC;
                            if (is_dec) begin
                                n_sat = dec_sat;
                                n_acc = dec_sat ? i_limit : dec_next[CP_W-1:0];
                            end
                        end
                    end
                    PH_HEX: begin
                        if (is_dec || is_hex_lo || is_hex_up) begin
                            n_sat = hex_sat;
                            n_acc = hex_sat ? i_limit : hex_next[CP_W-1:0];
                        end
                    end
                    default: begin
                        n_phase    = PH_IDLE;
                        n_span     = '0;
                        n_acc      = '0;
                        n_sat      = 1'b0;
                        n_name     = '0;
                        n_name_cnt = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_acc      <= '0;
            r_sat      <= 1'b0;
            r_name     <= '0;
            r_name_cnt <= '0;
            r_span     <= '0;
        end else if (i_advance) begin
            r_phase    <= n_phase;
            r_acc      <= n_acc;
            r_sat      <= n_sat;
            r_name     <= n_name;
            r_name_cnt <= n_name_cnt;
            r_span     <= n_span;
        end
    end

endmodule

// ===== rtl/core/crd_outreg.sv =====
// ----------------------------------------------------------------------------
// crd_outreg
// Result register: holds one decoded word until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crd_outreg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  crd_pkg::t_result i_result,
    input  logic             i_stall,
    output logic             o_valid,
    output logic             o_ready,
    output crd_pkg::t_result o_result
);
    import crd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready  = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== rtl/core/char_reference_decoder_core.sv =====
// ----------------------------------------------------------------------------
// char_reference_decoder_core
// Decodes character references ("&amp;", "&#65;", "&#x41;") from a byte
// stream into a code point, an error flag and the reference's byte span.
//
// Input channel: i_valid / o_stall with i_text_byte, one byte per word.
// Bytes outside a reference are dropped; '&' opens and ';' closes one.
// Output channel: o_valid / i_stall with o_cp_value, o_error_code and
// o_ref_span; one word leaves for every ';' that closes a reference.
// Configuration: i_cfg_we writes i_cfg_wdata to the code point limit.
//
// Each byte passes an input register, then the combinational decode into
// the result register, which loads the word of an accepted ';' and raises
// o_valid. One byte is accepted every cycle unless a closing ';' waits on
// a held result; the rate is set by the single decode stage between the
// two registers.
// Reset empties both registers, returns to idle and sets the limit to
// 1114111. While the receiver stalls a held result, bytes that produce
// no result keep flowing; a closing ';' waits in the input register and
// stalls the input side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module char_reference_decoder_core #(
    parameter int NAME_CHARS = crd_pkg::NAME_CHARS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [crd_pkg::CP_W-1:0]    i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [crd_pkg::BYTE_W-1:0]  i_text_byte,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [crd_pkg::CP_W-1:0]    o_cp_value,
    output logic                        o_error_code,
    output logic [crd_pkg::SPAN_W-1:0]  o_ref_span
);
    import crd_pkg::*;

    logic [CP_W-1:0]   r_limit;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    logic    emit;
    logic    advance;
    logic    out_ready;
    t_result scan_result;
    t_result out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= CP_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    assign advance = r_in_valid && (!emit || out_ready);
    assign o_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_text_byte;
        end
    end

    crd_scan #(
        .NAME_CHARS (NAME_CHARS)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .i_limit   (r_limit),
        .o_emit    (emit),
        .o_result  (scan_result)
    );

    crd_outreg u_outreg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && emit),
        .i_result (scan_result),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_ready  (out_ready),
        .o_result (out_result)
    );

    assign o_cp_value   = out_result.cp_value;
    assign o_error_code = out_result.error_code;
    assign o_ref_span   = out_result.ref_span;

    a_err_zero_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code |-> o_cp_value == '0)
        else $error("error result carries a nonzero code point");

    a_span_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_ref_span >= SPAN_W'(2))
        else $error("reference span shorter than its delimiters");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && emit && o_valid && i_stall)
        else $error("input stalled without a blocked result");

endmodule

// ===== sim/tb_char_reference_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_char_reference_decoder_core
// Self-checking bench for the character reference decoder core.
//
// A short table of hand-written references with their decoded words typed
// in comes first. Random phases follow: decimal, hex and named references,
// odd names, stray bytes, unterminated and very long references. The first
// and last phase use the reset code point limit, the others their own.
// A scan model, updated on every byte taken, predicts each result word.
// Both sides pause in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_char_reference_decoder_core;

    import crd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPENED,
        ST_HASH,
        ST_DEC,
        ST_HEX,
        ST_NAME
    } t_scan_state;

    typedef enum int {
        GEN_DEC,
        GEN_HEX,
        GEN_NAMED,
        GEN_ODD_NAME,
        GEN_NOISE,
        GEN_BROKEN,
        GEN_LONG
    } t_gen_kind;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CP_W-1:0]   i_cfg_wdata;
    logic              i_valid;
    logic              o_stall;
    logic [BYTE_W-1:0] i_text_byte;
    logic              o_valid;
    logic              i_stall;
    logic [CP_W-1:0]   o_cp_value;
    logic              o_error_code;
    logic [SPAN_W-1:0] o_ref_span;

    char_reference_decoder_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_text_byte  (i_text_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cp_value   (o_cp_value),
        .o_error_code (o_error_code),
        .o_ref_span   (o_ref_span)
    );

    // scan model state
    t_scan_state       scan_st;
    logic [CP_W-1:0]   cp_limit;
    logic [CP_W-1:0]   acc;
    logic              sat;
    logic [31:0]       name_chars;
    logic [2:0]        name_cnt;
    logic [SPAN_W-1:0] span_cnt;

    t_result           pending_refs [$];
    logic [BYTE_W-1:0] ref_bytes [$];
    string             known_names [5] = '{"amp", "apos", "gt", "lt", "quot"};
    string             case_text [6];
    t_result           case_want [6];

    int                errors;
    int                stall_left;
    bit                idle_on;

    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(negedge i_clk) begin
        if (stall_left == 0 && idle_on && i_rst_n && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 9);
        end else if (stall_left > 0) begin
            stall_left--;
        end
        i_stall <= (stall_left > 0);
    end

    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_refs.size() == 0) begin
                $display("%0t unexpected word cp %0d err %0d span %0d", $time,
                         o_cp_value, o_error_code, o_ref_span);
                errors++;
            end else begin
                w = pending_refs.pop_front();
                if (o_cp_value !== w.cp_value) begin
                    $display("%0t cp_value exp %0d got %0d", $time,
                             w.cp_value, o_cp_value);
                    errors++;
                end
                if (o_error_code !== w.error_code) begin
                    $display("%0t error_code exp %0d got %0d", $time,
                             w.error_code, o_error_code);
                    errors++;
                end
                if (o_ref_span !== w.ref_span) begin
                    $display("%0t ref_span exp %0d got %0d", $time,
                             w.ref_span, o_ref_span);
                    errors++;
                end
            end
        end
    end

    function automatic void clear_ref();
        acc        = '0;
        sat        = 1'b0;
        name_chars = '0;
        name_cnt   = '0;
    endfunction

    function automatic void add_digit(input int unsigned base, input int unsigned digit);
        longint unsigned nxt;
        nxt = longint'(acc) * base + digit;
        if (sat || nxt > cp_limit) begin
            sat = 1'b1;
            acc = cp_limit;
        end else begin
            acc = nxt[CP_W-1:0];
        end
    endfunction

    function automatic void keep_name(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        if (name_cnt < NAME_CHARS_DEF) begin
            c = (b >= CH_A_UP && b <= CH_Z_UP) ? b + 8'd32 : b;
            name_chars[8*name_cnt +: 8] = c;
            name_cnt++;
        end
    endfunction

    function automatic void dec_digit(input logic [BYTE_W-1:0] b);
        if (b >= CH_0 && b <= CH_9) add_digit(10, 32'(b - CH_0));
    endfunction

    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output t_result r);
        logic [CP_W-1:0] cp;
        logic            err;
        r = '0;
        if (b == CH_AMP) begin
            clear_ref();
            scan_st  = ST_OPENED;
            span_cnt = 8'd1;
            return 1'b0;
        end
        if (scan_st == ST_IDLE) return 1'b0;
        if (span_cnt < 8'd255) span_cnt++;
        if (b == CH_SEMI) begin
            cp  = '0;
            err = ERR_OK;
            if (scan_st == ST_OPENED || scan_st == ST_NAME) begin
                if (name_cnt == LEN_AMP && name_chars == NAME_AMP) cp = CP_W'(CP_AMP);
                else if (name_cnt == LEN_APOS && name_chars == NAME_APOS) cp = CP_W'(CP_APOS);
                else if (name_cnt == LEN_GT && name_chars == NAME_GT) cp = CP_W'(CP_GT);
                else if (name_cnt == LEN_LT && name_chars == NAME_LT) cp = CP_W'(CP_LT);
                else if (name_cnt == LEN_QUOT && name_chars == NAME_QUOT) cp = CP_W'(CP_QUOT);
                else err = ERR_UNKNOWN;
                if (err == ERR_OK && cp > cp_limit) cp = cp_limit;
            end else begin
                cp = acc;
            end
            r.cp_value   = cp;
            r.error_code = err;
            r.ref_span   = span_cnt;
            scan_st  = ST_IDLE;
            span_cnt = '0;
            clear_ref();
            return 1'b1;
        end
        case (scan_st)
            ST_OPENED: begin
                if (b == CH_HASH) begin
                    scan_st = ST_HASH;
                end else begin
                    scan_st = ST_NAME;
                    keep_name(b);
                end
            end
            ST_NAME: keep_name(b);
            ST_HASH: begin
                if (b == CH_X_LO || b == CH_X_UP) begin
                    scan_st = ST_HEX;
                end else begin
                    scan_st = ST_DEC;
                    dec_digit(b);
                end
            end
            ST_DEC: dec_digit(b);
            ST_HEX: begin
                if (b >= CH_0 && b <= CH_9) add_digit(16, 32'(b - CH_0));
                else if (b >= CH_A_LO && b <= CH_F_LO) add_digit(16, b - CH_A_LO + 10);
                else if (b >= CH_A_UP && b <= CH_F_UP) add_digit(16, b - CH_A_UP + 10);
            end
            default: begin
                scan_st  = ST_IDLE;
                span_cnt = '0;
                clear_ref();
            end
        endcase
        return 1'b0;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed,
                             input t_result typed_word);
        int      gap;
        t_result r;
        bit      emitted;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 9);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_text_byte <= b;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        emitted = decode_byte(b, r);
        if (typed) pending_refs.push_back(typed_word);
        else if (emitted) pending_refs.push_back(r);
    endtask

    task automatic set_limit(input logic [CP_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cp_limit = v;
    endtask

    // close any open reference, then let the pipeline run dry
    task automatic end_phase();
        send_byte(CH_SEMI, 1'b0, '0);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_refs.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(0, 255)); while (b == CH_AMP || b == CH_SEMI);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] hex_digit();
        int unsigned v;
        v = $urandom_range(0, 15);
        if (v < 10) return BYTE_W'(CH_0 + v);
        return BYTE_W'(($urandom_range(0, 1) ? CH_A_LO : CH_A_UP) + v - 10);
    endfunction

    function automatic t_gen_kind pick_kind();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 5) return GEN_DEC;
        if (r < 9) return GEN_HEX;
        if (r < 14) return GEN_NAMED;
        if (r < 16) return GEN_ODD_NAME;
        if (r < 18) return GEN_NOISE;
        return GEN_BROKEN;
    endfunction

    function automatic void build_ref(input t_gen_kind kind);
        int                n;
        string             s;
        logic [BYTE_W-1:0] c;
        ref_bytes.delete();
        if (kind != GEN_NOISE) ref_bytes.push_back(CH_AMP);
        case (kind)
            GEN_DEC: begin
                ref_bytes.push_back(CH_HASH);
                n = $urandom_range(0, 8);
                repeat (n) begin
                    if ($urandom_range(0, 15) == 0) ref_bytes.push_back(plain_byte());
                    else ref_bytes.push_back(BYTE_W'(CH_0 + $urandom_range(0, 9)));
                end
            end
            GEN_HEX: begin
                ref_bytes.push_back(CH_HASH);
                ref_bytes.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
                n = $urandom_range(0, 7);
                repeat (n) begin
                    if ($urandom_range(0, 15) == 0) ref_bytes.push_back(plain_byte());
                    else ref_bytes.push_back(hex_digit());
                end
            end
            GEN_NAMED: begin
                s = known_names[$urandom_range(0, 4)];
                for (int i = 0; i < s.len(); i++) begin
                    c = s[i];
                    if ($urandom_range(0, 1)) c = c - 8'd32;
                    ref_bytes.push_back(c);
                end
                if ($urandom_range(0, 3) == 0) begin
                    n = $urandom_range(1, 3);
                    repeat (n) ref_bytes.push_back(plain_byte());
                end
            end
            GEN_ODD_NAME: begin
                n = $urandom_range(0, 6);
                repeat (n) ref_bytes.push_back(plain_byte());
            end
            GEN_NOISE: begin
                n = $urandom_range(1, 6);
                repeat (n) ref_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
            end
            GEN_BROKEN: begin
                n = $urandom_range(0, 4);
                repeat (n) ref_bytes.push_back(plain_byte());
            end
            GEN_LONG: begin
                ref_bytes.push_back(CH_HASH);
                repeat (280) ref_bytes.push_back(plain_byte());
            end
            default: ;
        endcase
        if (kind != GEN_NOISE && kind != GEN_BROKEN) ref_bytes.push_back(CH_SEMI);
    endfunction

    task automatic run_random(input int count, input bit with_long);
        int        sent;
        t_gen_kind kind;
        sent = 0;
        while (sent < count) begin
            kind = pick_kind();
            if (with_long && sent == 0) kind = GEN_LONG;
            build_ref(kind);
            foreach (ref_bytes[i]) send_byte(ref_bytes[i], 1'b0, '0);
            sent += ref_bytes.size();
        end
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_valid     = 1'b0;
        i_text_byte = '0;
        i_stall     = 1'b0;
        errors      = 0;
        stall_left  = 0;
        idle_on     = 1'b1;
        scan_st     = ST_IDLE;
        span_cnt    = '0;
        cp_limit    = CP_LIMIT_RST;
        clear_ref();

        case_text[0] = "\377&lt;";      case_want[0] = '{21'd60, ERR_OK, 8'd4};
        case_text[1] = "&;";            case_want[1] = '{21'd0, ERR_UNKNOWN, 8'd2};
        case_text[2] = "&#;";           case_want[2] = '{21'd0, ERR_OK, 8'd3};
        case_text[3] = "&&GT;";         case_want[3] = '{21'd62, ERR_OK, 8'd4};
        case_text[4] = "&#X!fFFFFF;";   case_want[4] = '{21'd1114111, ERR_OK, 8'd11};
        case_text[5] = "&QUOTe;";       case_want[5] = '{21'd34, ERR_OK, 8'd7};

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (case_text[i]) begin
            for (int j = 0; j < case_text[i].len(); j++) begin
                send_byte(case_text[i][j], j == case_text[i].len() - 1, case_want[i]);
            end
        end

        run_random(300, 1'b0);
        end_phase();
        set_limit('0);
        run_random(250, 1'b0);
        end_phase();
        set_limit(21'h1FFFFF);
        run_random(300, 1'b1);
        end_phase();
        set_limit(CP_W'($urandom_range(32, 100)));
        run_random(250, 1'b0);
        end_phase();
        idle_on = 1'b0;
        set_limit(CP_LIMIT_RST);
        run_random(250, 1'b0);
        end_phase();

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
